// ===== rtl/tageh_pkg.sv =====
`default_nettype none
package tageh_pkg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } t_state;

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [14:0] THRESH_RESET = 15'd13658;

    // pt in Q12.4
    localparam logic [15:0] PT_CLAMP_AT = 16'd16000;
    localparam logic [15:0] PT_CLAMPED  = 16'd15999;
    localparam logic [15:0] PT_MIN      = 16'd480;
    localparam int          PT_EDGE_NUM = 7;

    typedef logic [15:0] t_pt_edges [PT_EDGE_NUM];
    localparam t_pt_edges PT_EDGES = '{
        16'd800, 16'd1120, 16'd1600, 16'd2240, 16'd3200, 16'd4800, 16'd9600
    };

    // |eta| bin = |eta| * bins * 5 / ETA_SCALE
    localparam int unsigned ETA_SCALE = 12288;
    localparam int unsigned ETA_MUL   = 5;

    localparam logic [6:0] FLAV_GLUON  = 7'd21;
    localparam logic [6:0] FLAV_CHARM  = 7'd4;
    localparam logic [6:0] FLAV_BOTTOM = 7'd5;
    localparam logic [6:0] FLAV_LIGHT_MAX = 7'd3;

    localparam logic [1:0] FBIN_LIGHT  = 2'd0;
    localparam logic [1:0] FBIN_CHARM  = 2'd1;
    localparam logic [1:0] FBIN_BOTTOM = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/tageh_ram.sv =====
`default_nettype none
module tageh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 288
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tag_efficiency_histogram.sv =====
// tag-efficiency histogram of jets binned by |eta|, pt and hadron flavor
//
// input channel: one beat is either a jet to accumulate (i_cmd low) or a
// readout of one bin (i_cmd high); a beat is taken when i_in_valid is high
// and o_in_stall is low. output channel: one result beat per input beat,
// in order, taken when o_out_valid is high and i_out_stall is low.
// config channel: i_cfg_valid/o_cfg_ready write the tag threshold; write
// it only while the block is idle.
//
// each beat is a read-modify-write: the count memory is read in the accept
// cycle and, for a counted jet, the incremented pair is written back in the
// update state, which also registers the result; no new beat is taken until
// then. the output register holds a result while the receiver stalls; the
// block then takes one more beat and holds it until the register frees.
//
// after reset the counts are cleared by one pass over the memory, one
// bin per cycle (FLAVOR_BINS*PT_BINS*ETA_BINS bins, 288 by default);
// o_in_stall stays high during that pass, config writes are still taken.
`default_nettype none
module tag_efficiency_histogram #(
    parameter int ETA_BINS    = 12,
    parameter int PT_BINS     = 8,
    parameter int FLAVOR_BINS = 3,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [14:0]        i_cfg_data,

    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_cmd,
    input  wire logic               i_event_start,
    input  wire logic               i_event_pass,
    input  wire logic signed [6:0]  i_hadron_flavor,
    input  wire logic [15:0]        i_jet_pt,
    input  wire logic signed [13:0] i_jet_eta,
    input  wire logic signed [15:0] i_discriminator,
    input  wire logic               i_is_lepton,
    input  wire logic               i_passes_id,
    input  wire logic               i_in_hem_region,
    input  wire logic [8:0]         i_read_bin,

    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_jet_counted,
    output logic                    o_jet_tagged,
    output logic [8:0]              o_bin_index,
    output logic [31:0]             o_tagged_count,
    output logic [31:0]             o_total_count
);

    localparam int NBINS = FLAVOR_BINS * PT_BINS * ETA_BINS;
    localparam int AW    = $clog2(NBINS);
    localparam int CW    = COUNT_WIDTH;
    localparam int EBW   = (ETA_BINS > 1) ? $clog2(ETA_BINS) : 1;
    localparam int PBW   = (PT_BINS > 1) ? $clog2(PT_BINS) : 1;
    localparam int PW    = 14 + $clog2(ETA_BINS * tageh_pkg::ETA_MUL + 1);

    tageh_pkg::t_state r_state, n_state;

    logic [AW-1:0]  r_clr_addr;
    logic [14:0]    r_thresh;
    logic           r_stop;
    logic           n_stop;

    // beat held between the memory read and the write back
    logic           r_cmd;
    logic           r_counted;
    logic           r_tagged;
    logic [AW-1:0]  r_bin;
    logic [8:0]     r_rd_bin;
    logic           r_rd_ok;

    logic           r_out_valid;
    logic           r_out_counted;
    logic           r_out_tagged;
    logic [8:0]     r_out_bin;
    logic [31:0]    r_out_tagged_cnt;
    logic [31:0]    r_out_total_cnt;

    logic           in_accept;
    logic           out_free;
    logic           update_go;
    logic           clr_we;

    logic [6:0]     flav_abs;
    logic [13:0]    eta_abs;
    logic [15:0]    pt_clamp;
    logic [PW-1:0]  eta_prod;
    logic [EBW-1:0] eta_bin;
    logic [PBW-1:0] pt_bin;
    logic [1:0]     flav_bin;
    logic           flav_ok;
    logic           eta_ok;
    logic           stop_eff;
    logic           jet_counted;
    logic           jet_tagged;
    logic [AW-1:0]  jet_bin;
    logic [AW-1:0]  rd_addr;

    logic [2*CW-1:0] ram_rdata;
    logic [2*CW-1:0] ram_wdata;
    logic [AW-1:0]   ram_waddr;
    logic            ram_we;
    logic [CW-1:0]   cnt_tagged;
    logic [CW-1:0]   cnt_total;
    logic [CW-1:0]   new_tagged;
    logic [CW-1:0]   new_total;
    logic [31:0]     rd_tagged32;
    logic [31:0]     rd_total32;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;

    // jet classification
    always_comb begin
        flav_abs = i_hadron_flavor[6] ? 7'(-i_hadron_flavor) : 7'(i_hadron_flavor);
        if (flav_abs == tageh_pkg::FLAV_GLUON) begin
            flav_abs = '0;
        end
        flav_ok  = 1'b1;
        flav_bin = tageh_pkg::FBIN_LIGHT;
        if (flav_abs <= tageh_pkg::FLAV_LIGHT_MAX) begin
            flav_bin = tageh_pkg::FBIN_LIGHT;
        end else if (flav_abs == tageh_pkg::FLAV_CHARM) begin
            flav_bin = tageh_pkg::FBIN_CHARM;
        end else if (flav_abs == tageh_pkg::FLAV_BOTTOM) begin
            flav_bin = tageh_pkg::FBIN_BOTTOM;
        end else begin
            flav_ok = 1'b0;
        end
    end

    always_comb begin
        eta_abs  = i_jet_eta[13] ? 14'(-i_jet_eta) : 14'(i_jet_eta);
        eta_prod = PW'(eta_abs) * PW'(ETA_BINS * tageh_pkg::ETA_MUL);
        eta_ok   = 32'(eta_prod) < 32'(ETA_BINS * tageh_pkg::ETA_SCALE);
        eta_bin  = '0;
        for (int k = 1; k < ETA_BINS; k++) begin
            if (32'(eta_prod) >= 32'(k * tageh_pkg::ETA_SCALE)) begin
                eta_bin = EBW'(k);
            end
        end
    end

    always_comb begin
        pt_clamp = (i_jet_pt >= tageh_pkg::PT_CLAMP_AT) ? tageh_pkg::PT_CLAMPED : i_jet_pt;
        pt_bin   = '0;
        for (int k = 0; k < tageh_pkg::PT_EDGE_NUM; k++) begin
            if (pt_clamp >= tageh_pkg::PT_EDGES[k]) begin
                pt_bin = (k + 1 > PT_BINS - 1) ? PBW'(PT_BINS - 1) : PBW'(k + 1);
            end
        end
    end

    always_comb begin
        stop_eff = r_stop && !i_event_start;
        n_stop   = r_stop;
        if (in_accept && i_cmd == tageh_pkg::CMD_ACCUM) begin
            n_stop = stop_eff;
            if (i_event_pass && !stop_eff && !i_is_lepton && i_jet_pt < tageh_pkg::PT_MIN) begin
                n_stop = 1'b1;
            end
        end
        jet_counted = i_event_pass && !stop_eff && !i_is_lepton
                      && (i_jet_pt >= tageh_pkg::PT_MIN) && eta_ok && i_passes_id
                      && !i_in_hem_region && flav_ok;
        jet_tagged  = jet_counted && (i_discriminator > $signed({1'b0, r_thresh}));
        jet_bin     = AW'(flav_bin) * AW'(PT_BINS * ETA_BINS)
                      + AW'(pt_bin) * AW'(ETA_BINS) + AW'(eta_bin);
        rd_addr     = (i_cmd == tageh_pkg::CMD_READ) ? AW'(i_read_bin) : jet_bin;
    end

    // state machine
    always_comb begin
        n_state = r_state;
        case (r_state)
            tageh_pkg::ST_CLEAR: begin
                if (r_clr_addr == AW'(NBINS - 1)) begin
                    n_state = tageh_pkg::ST_IDLE;
                end
            end
            tageh_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = tageh_pkg::ST_UPDATE;
                end
            end
            tageh_pkg::ST_UPDATE: begin
                if (out_free) begin
                    n_state = tageh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tageh_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        update_go  = 1'b0;
        clr_we     = 1'b0;
        case (r_state)
            tageh_pkg::ST_CLEAR: begin
                clr_we = 1'b1;
            end
            tageh_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            tageh_pkg::ST_UPDATE: begin
                update_go = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // read-modify-write of the count pair
    assign cnt_tagged = ram_rdata[2*CW-1:CW];
    assign cnt_total  = ram_rdata[CW-1:0];
    assign new_total  = (&cnt_total) ? cnt_total : cnt_total + CW'(1);
    assign new_tagged = (r_tagged && !(&cnt_tagged)) ? cnt_tagged + CW'(1) : cnt_tagged;

    assign ram_we    = clr_we || (update_go && r_cmd == tageh_pkg::CMD_ACCUM && r_counted);
    assign ram_waddr = clr_we ? r_clr_addr : r_bin;
    assign ram_wdata = clr_we ? '0 : {new_tagged, new_total};

    tageh_ram #(
        .WIDTH (2 * CW),
        .DEPTH (NBINS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    generate
        if (CW > 32) begin : g_sat
            assign rd_tagged32 = (|cnt_tagged[CW-1:32]) ? '1 : cnt_tagged[31:0];
            assign rd_total32  = (|cnt_total[CW-1:32]) ? '1 : cnt_total[31:0];
        end else begin : g_ext
            assign rd_tagged32 = 32'(cnt_tagged);
            assign rd_total32  = 32'(cnt_total);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tageh_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_thresh    <= tageh_pkg::THRESH_RESET;
            r_stop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stop  <= n_stop;
            if (clr_we) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_thresh <= i_cfg_data;
            end
            if (update_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd     <= i_cmd;
            r_counted <= jet_counted;
            r_tagged  <= jet_tagged;
            r_bin     <= jet_bin;
            r_rd_bin  <= i_read_bin;
            r_rd_ok   <= 32'(i_read_bin) < 32'(NBINS);
        end
        if (update_go) begin
            if (r_cmd == tageh_pkg::CMD_READ) begin
                r_out_counted    <= 1'b0;
                r_out_tagged     <= 1'b0;
                r_out_bin        <= r_rd_bin;
                r_out_tagged_cnt <= r_rd_ok ? rd_tagged32 : '0;
                r_out_total_cnt  <= r_rd_ok ? rd_total32 : '0;
            end else begin
                r_out_counted    <= r_counted;
                r_out_tagged     <= r_tagged;
                r_out_bin        <= r_counted ? 9'(r_bin) : '0;
                r_out_tagged_cnt <= '0;
                r_out_total_cnt  <= '0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_jet_counted  = r_out_counted;
    assign o_jet_tagged   = r_out_tagged;
    assign o_bin_index    = r_out_bin;
    assign o_tagged_count = r_out_tagged_cnt;
    assign o_total_count  = r_out_total_cnt;

endmodule
`default_nettype wire
